/* src/skc_pkg.sv */
// Package for the SPI keyboard controller: widths, request codes and scan tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package skc_pkg;

   localparam int COLUMNS     = 16;
   localparam int QUEUE_DEPTH = 128;

   typedef enum logic [2:0] {
      REQ_EXCHANGE = 3'd0,
      REQ_OUT_EN   = 3'd1,
      REQ_BUTTON   = 3'd2,
      REQ_KEY      = 3'd3,
      REQ_IRQ_POLL = 3'd4
   } req_code_type;

   localparam logic [7:0] OE_REPLY   = 8'haa;
   localparam logic [7:0] COUNT_FLAG = 8'h40;

   // Scan code of a button; codes with bit 7 set touch no matrix bit.
   function automatic logic [7:0] button_code(input logic [5:0] id);
      logic [7:0] c;
      case (id)
         6'd0:  c = 8'hff; 6'd1:  c = 8'h0f; 6'd2:  c = 8'h70; 6'd3:  c = 8'h12;
         6'd4:  c = 8'h4e; 6'd5:  c = 8'h5e; 6'd6:  c = 8'h60; 6'd7:  c = 8'h53;
         6'd8:  c = 8'h4c; 6'd9:  c = 8'h4d; 6'd10: c = 8'h0d; 6'd11: c = 8'h1d;
         6'd12: c = 8'h1e; 6'd13: c = 8'h17; 6'd14: c = 8'h05; 6'd15: c = 8'h45;
         6'd16: c = 8'h4e; 6'd17: c = 8'h5e; 6'd18: c = 8'h60; 6'd19: c = 8'h53;
         6'd20: c = 8'h33; 6'd21: c = 8'h62; 6'd22: c = 8'h41; 6'd23: c = 8'h40;
         6'd24: c = 8'h66; 6'd25: c = 8'h0c; 6'd26: c = 8'h73;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   localparam logic [7:0] CHAR_TABLE [128] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h0e, 8'h0b, 8'h6e, 8'h00, 8'h00, 8'h6e, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h73, 8'h72, 8'h71, 8'h70, 8'h12,
      8'h7e, 8'h5b, 8'h14, 8'h5d, 8'h5a, 8'h4a, 8'h58, 8'h14,
      8'h55, 8'h54, 8'h57, 8'h47, 8'h67, 8'h44, 8'h65, 8'h74,
      8'h54, 8'h5b, 8'h5c, 8'h5d, 8'h5a, 8'h4a, 8'h48, 8'h58,
      8'h57, 8'h55, 8'h24, 8'h24, 8'h67, 8'h47, 8'h65, 8'h74,
      8'h5c, 8'h2b, 8'h7a, 8'h6d, 8'h2d, 8'h3d, 8'h2a, 8'h1a,
      8'h18, 8'h37, 8'h28, 8'h27, 8'h25, 8'h68, 8'h78, 8'h35,
      8'h34, 8'h3b, 8'h3a, 8'h2c, 8'h0a, 8'h38, 8'h6a, 8'h3c,
      8'h6c, 8'h08, 8'h6b, 8'h04, 8'h2e, 8'h07, 8'h48, 8'h44,
      8'h4b, 8'h2b, 8'h7a, 8'h6d, 8'h2d, 8'h3d, 8'h2a, 8'h1a,
      8'h18, 8'h37, 8'h28, 8'h27, 8'h25, 8'h68, 8'h78, 8'h35,
      8'h34, 8'h3b, 8'h3a, 8'h2c, 8'h0a, 8'h38, 8'h6a, 8'h3c,
      8'h6c, 8'h08, 8'h6b, 8'h04, 8'h2e, 8'h07, 8'h4b, 8'h00
   };

   function automatic logic [7:0] char_code(input logic [7:0] ch);
      return ch[7] ? 8'h00 : CHAR_TABLE[ch[6:0]];
   endfunction

   localparam logic [7:0] CMD_TEXT [8] = '{
      8'h47, 8'h65, 8'h74, 8'h20, 8'h56, 8'h65, 8'h72, 8'h21
   };
   localparam logic [7:0] VER_TEXT [4] = '{8'h30, 8'h36, 8'h2e, 8'h38};

endpackage
`default_nettype wire

/* src/skc_version_match.sv */
// Version command matcher: tracks "Get Ver!" and plays back the version reply.
// Depends on skc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module skc_version_match (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] cmd,
   output logic            replying,
   output logic [7:0]      reply_byte
);
   logic [3:0] match_pos_ff, match_pos_in;
   logic [2:0] reply_pos_ff, reply_pos_in;
   logic       in_reply_ff, in_reply_in;

   assign replying = in_reply_ff;

   // Advance the matcher or the reply pointer
   always_comb begin
      match_pos_in = match_pos_ff;
      reply_pos_in = reply_pos_ff;
      in_reply_in  = in_reply_ff;
      reply_byte   = 8'h00;
      if (in_reply_ff) begin
         reply_byte   = skc_pkg::VER_TEXT[reply_pos_ff[1:0]];
         reply_pos_in = reply_pos_ff + 3'd1;
         if (reply_pos_in >= 3'd4) begin
            match_pos_in = 4'd0;
            reply_pos_in = 3'd0;
            in_reply_in  = 1'b0;
         end
      end else if (skc_pkg::CMD_TEXT[match_pos_ff[2:0]] == cmd) begin
         match_pos_in = match_pos_ff + 4'd1;
         if (match_pos_in >= 4'd8) begin
            in_reply_in  = 1'b1;
            reply_pos_in = 3'd0;
         end
      end else begin
         match_pos_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_pos_ff <= '0;
         reply_pos_ff <= '0;
         in_reply_ff  <= 1'b0;
      end else if (step) begin
         match_pos_ff <= match_pos_in;
         reply_pos_ff <= reply_pos_in;
         in_reply_ff  <= in_reply_in;
      end
   end
endmodule
`default_nettype wire

/* src/spi_keyboard_controller_core.sv */
// SPI keyboard controller top level: request decode, key matrix, scan sequencer, queue.
// Depends on skc_pkg and skc_version_match.
//
// Usage: raise start with a req_ transaction while busy is low. The block
// answers each transaction with one rsp_ transaction, rsp_valid high for
// one cycle. Most requests pass the decode state on the way to the answer.
// An exchange that triggers an event scan passes the button state (if a
// button is posted) and the key state, then walks the 128 matrix bits one
// per cycle through a single bit test/queue-write unit. A scan byte read
// from the queue memory passes the decode and read states. busy stays high
// from acceptance until the answer cycle ends. The receiver cannot stall:
// the answer is shown once and taken. Reset clears the matrix, slots, pointers and
// flags; the scan queue memory is not cleared (it is only read below its fill count).
`timescale 1ns / 1ps
`default_nettype none
module spi_keyboard_controller_core #(
   parameter int COLUMNS     = skc_pkg::COLUMNS,
   parameter int QUEUE_DEPTH = skc_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_type,
   input  wire logic [15:0] req_spi_word,
   input  wire logic [5:0]  req_button_id,
   input  wire logic        req_button_down,
   input  wire logic [7:0]  req_key_char,
   input  wire logic        req_key_shift,
   input  wire logic        req_key_control,
   output logic             rsp_valid,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_irq_request
);
   localparam int CW = $clog2(COLUMNS);
   localparam int QW = $clog2(QUEUE_DEPTH);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DECODE = 7'b0000010,
      ST_BUTTON = 7'b0000100,
      ST_KEY    = 7'b0001000,
      ST_SCAN   = 7'b0010000,
      ST_READ   = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [7:0]  pressed_ff [COLUMNS];
   logic [7:0]  latched_ff [COLUMNS];
   logic [7:0]  queue_mem [QUEUE_DEPTH];
   logic [7:0]  queue_rd_ff;
   logic [7:0]  fill_ff, read_ff;
   logic        pending_ff, sticky_ff, oe_ff, key_busy_ff, blocked_ff;
   logic        btn_valid_ff, btn_down_ff;
   logic [5:0]  btn_id_ff;
   logic        key_valid_ff, key_ctl_ff, key_sh_ff;
   logic [7:0]  key_ch_ff;
   logic [2:0]  rq_type_ff;
   logic [15:0] rq_word_ff;
   logic [CW+2:0] scan_ff;
   logic [7:0]  data_ff;
   logic        irq_ff;

   logic       ver_step, ver_replying;
   logic [7:0] ver_byte;

   skc_version_match u_match (
      .clock      (clock),
      .reset      (reset),
      .step       (ver_step),
      .cmd        (rq_word_ff[7:0]),
      .replying   (ver_replying),
      .reply_byte (ver_byte)
   );

   wire logic accept = start && !busy;
   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_DONE);
   assign rsp_read_data   = data_ff;
   assign rsp_irq_request = irq_ff;

   wire logic is_xchg  = (rq_type_ff == skc_pkg::REQ_EXCHANGE);
   wire logic oe_path  = is_xchg && oe_ff;
   wire logic ver_path = is_xchg && !oe_ff && (rq_word_ff != 16'h0 || ver_replying);
   wire logic rd_path  = is_xchg && !oe_ff && !ver_path && fill_ff != 8'h0;
   wire logic scn_path = is_xchg && !oe_ff && !ver_path && fill_ff == 8'h0;
   assign ver_step = (state_ff == ST_DECODE) && ver_path;

   // Scan walker fields: column high, bit low
   wire logic [CW-1:0] sc_col = scan_ff[CW+2:3];
   wire logic [2:0]    sc_bit = scan_ff[2:0];
   wire logic          sc_hit = pressed_ff[sc_col][sc_bit];

   // Key post decode
   wire logic [7:0]    kcode = skc_pkg::char_code(key_ch_ff);
   wire logic [CW-1:0] kcol  = kcode[CW-1:0];
   wire logic [7:0]    kmask = 8'h01 << kcode[6:4];
   wire logic [7:0]    bcode = skc_pkg::button_code(btn_id_ff);

   // Sequence the transaction
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_DECODE;
         ST_DECODE: begin
            if (scn_path) state_in = btn_valid_ff ? ST_BUTTON : ST_KEY;
            else if (rd_path) state_in = ST_READ;
            else state_in = ST_DONE;
         end
         ST_BUTTON: state_in = ST_KEY;
         ST_KEY:    state_in = ST_SCAN;
         ST_SCAN:   if (&scan_ff) state_in = ST_DONE;
         ST_READ:   state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // Read the queue memory; write each pressed bit found during the scan
   always_ff @(posedge clock) begin
      queue_rd_ff <= queue_mem[read_ff[QW-1:0]];
      if (state_ff == ST_SCAN && sc_hit)
         queue_mem[fill_ff[QW-1:0]] <= {1'b0, sc_bit, sc_col};
   end

   // Hold request, update matrix, slots and flags
   always_ff @(posedge clock) begin
      if (accept) begin
         rq_type_ff <= req_type;
         rq_word_ff <= req_spi_word;
      end
      if (reset) begin
         for (int c = 0; c < COLUMNS; c++) begin
            pressed_ff[c] <= 8'h0;
            latched_ff[c] <= 8'h0;
         end
         fill_ff <= 8'h0; read_ff <= 8'h0;
         pending_ff <= 1'b0; sticky_ff <= 1'b0; oe_ff <= 1'b0;
         key_busy_ff <= 1'b0; blocked_ff <= 1'b0;
         btn_valid_ff <= 1'b0; btn_down_ff <= 1'b0; btn_id_ff <= 6'd0;
         key_valid_ff <= 1'b0; key_ctl_ff <= 1'b0; key_sh_ff <= 1'b0;
         key_ch_ff <= 8'h0;
         scan_ff <= '0; data_ff <= 8'h0; irq_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  data_ff <= 8'h0;
                  irq_ff  <= 1'b0;
                  case (req_type)
                     skc_pkg::REQ_OUT_EN: oe_ff <= 1'b1;
                     skc_pkg::REQ_BUTTON: begin
                        btn_valid_ff <= 1'b1;
                        btn_id_ff    <= req_button_id;
                        btn_down_ff  <= req_button_down;
                     end
                     skc_pkg::REQ_KEY: begin
                        key_valid_ff <= 1'b1;
                        key_ch_ff    <= req_key_char;
                        key_sh_ff    <= req_key_shift;
                        key_ctl_ff   <= req_key_control;
                     end
                     skc_pkg::REQ_IRQ_POLL: begin
                        if (!pending_ff) begin
                           pending_ff <= btn_valid_ff || (key_valid_ff && !key_ctl_ff);
                           irq_ff <= btn_valid_ff || (key_valid_ff && !key_ctl_ff);
                        end else begin
                           irq_ff <= 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_DECODE: begin
               if (oe_path) begin
                  fill_ff <= 8'h0; read_ff <= 8'h0; oe_ff <= 1'b0;
                  data_ff <= skc_pkg::OE_REPLY;
               end else if (ver_path) begin
                  fill_ff <= 8'h0; read_ff <= 8'h0;
                  data_ff <= ver_byte;
               end else if (scn_path) begin
                  blocked_ff  <= key_busy_ff;
                  key_busy_ff <= 1'b0;
                  scan_ff     <= '0;
               end
            end
            ST_BUTTON: begin
               btn_valid_ff <= 1'b0;
               if (btn_id_ff == 6'd27 || btn_id_ff == 6'd28 || btn_id_ff == 6'd29) begin
                  if (btn_down_ff) begin
                     if (btn_id_ff == 6'd27) begin
                        pressed_ff[4'hb][7] <= !pressed_ff[4'hb][7];
                        latched_ff[4'hb][7] <= !pressed_ff[4'hb][7];
                     end else if (btn_id_ff == 6'd28) begin
                        pressed_ff[4'h6][4] <= !pressed_ff[4'h6][4];
                        latched_ff[4'h6][4] <= !pressed_ff[4'h6][4];
                     end else begin
                        pressed_ff[4'h3][1] <= !pressed_ff[4'h3][1];
                        latched_ff[4'h3][1] <= !pressed_ff[4'h3][1];
                     end
                  end
               end else if (btn_id_ff == 6'd30 || btn_id_ff == 6'd31) begin
                  if (btn_down_ff) begin
                     if (btn_id_ff == 6'd30) begin
                        pressed_ff[4'h9][0] <= !pressed_ff[4'h9][0];
                        latched_ff[4'h9][0] <= !pressed_ff[4'h9][0];
                        sticky_ff           <= !pressed_ff[4'h9][0];
                     end else begin
                        pressed_ff[4'h9][6] <= !pressed_ff[4'h9][6];
                        latched_ff[4'h9][6] <= !pressed_ff[4'h9][6];
                        sticky_ff           <= !pressed_ff[4'h9][6];
                     end
                  end
               end else if (btn_id_ff == 6'd32) begin
                  if (btn_down_ff) begin
                     pressed_ff[4'hb][7] <= 1'b0; latched_ff[4'hb][7] <= 1'b0;
                     pressed_ff[4'h6][4] <= 1'b0; latched_ff[4'h6][4] <= 1'b0;
                     pressed_ff[4'h9][6] <= 1'b0; latched_ff[4'h9][6] <= 1'b0;
                     pressed_ff[4'h9][0] <= 1'b0; latched_ff[4'h9][0] <= 1'b0;
                     pressed_ff[4'h3][1] <= 1'b0; latched_ff[4'h3][1] <= 1'b0;
                  end
               end else begin
                  if (!bcode[7]) begin
                     pressed_ff[bcode[3:0]][bcode[6:4]] <= btn_down_ff;
                     latched_ff[bcode[3:0]][bcode[6:4]] <= btn_down_ff;
                  end
                  // Up and down arrows also drive the alt bit
                  if (bcode == 8'h12 || bcode == 8'h70) begin
                     pressed_ff[4'h6][4] <= btn_down_ff;
                     latched_ff[4'h6][4] <= btn_down_ff;
                  end
               end
            end
            ST_KEY: begin
               if (key_valid_ff && !key_ctl_ff && !blocked_ff
                   && (pressed_ff[kcol] & kmask) == 8'h0) begin
                  key_valid_ff <= 1'b0;
                  key_busy_ff  <= 1'b1;
                  if (!sticky_ff) begin
                     for (int c = 0; c < COLUMNS; c++) begin
                        if (c == 9) begin
                           pressed_ff[c] <= ((pressed_ff[c] & 8'hfe) | {7'h0, key_sh_ff})
                                            | ((kcol == CW'(c)) ? kmask : 8'h0);
                           latched_ff[c] <= latched_ff[c] & 8'hfe
                                            & ((kcol == CW'(c)) ? ~kmask : 8'hff);
                        end else if (kcol == CW'(c)) begin
                           pressed_ff[c] <= pressed_ff[c] | kmask;
                           latched_ff[c] <= latched_ff[c] & ~kmask;
                        end
                     end
                  end else begin
                     pressed_ff[kcol] <= pressed_ff[kcol] | kmask;
                     latched_ff[kcol] <= latched_ff[kcol] & ~kmask;
                  end
               end
               fill_ff <= 8'h0;
            end
            ST_SCAN: begin
               // Queue one pressed bit per cycle, drop unlatched bits
               if (sc_hit) begin
                  fill_ff <= fill_ff + 8'd1;
                  if (!latched_ff[sc_col][sc_bit]) pressed_ff[sc_col][sc_bit] <= 1'b0;
               end
               scan_ff <= scan_ff + 1'b1;
               if (&scan_ff) begin
                  read_ff    <= 8'h0;
                  pending_ff <= 1'b0;
                  data_ff    <= (fill_ff + {7'h0, sc_hit} == 8'h0) ? 8'h0
                                : ((fill_ff + {7'h0, sc_hit}) | skc_pkg::COUNT_FLAG);
               end
            end
            ST_READ: begin
               data_ff <= queue_rd_ff;
               if (read_ff + 8'd1 == fill_ff) begin
                  fill_ff <= 8'h0; read_ff <= 8'h0;
               end else begin
                  read_ff <= read_ff + 8'd1;
               end
            end
            ST_DONE: ;
            default: ;
         endcase
      end
   end

`ifndef SYNTHESIS
   // An answer is followed by idle; queue reads stay below the fill count, which stays within the depth
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("answer not followed by idle");
   a_read_below_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (read_ff < fill_ff)) else $error("queue read past fill");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 8'(QUEUE_DEPTH)) else $error("queue overfill");
`endif
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Testbench for spi_keyboard_controller_core: drives requests through the start/busy
// handshake and checks each answer against a built-in model. Depends on skc_pkg and the RTL.
`timescale 1ns / 1ps
`default_nettype none

class keyboard_scoreboard;
   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_request;
   } answer_type;

   // model state
   logic [7:0] pressed_map [16];
   logic [7:0] latched_map [16];
   logic [7:0] scan_queue  [128];
   logic [7:0] queue_fill, queue_read;
   bit pending_irq, sticky_shift, in_version_reply, output_enable_flag, key_busy;
   logic [3:0] match_pos;
   logic [2:0] reply_pos;
   bit btn_valid, btn_down;
   logic [5:0] btn_id;
   bit key_valid, key_ctl, key_sh;
   logic [7:0] key_ch;

   answer_type pending_answers [$];
   int error_count;

   function new();
      for (int i = 0; i < 16; i++) begin
         pressed_map[i] = 0;
         latched_map[i] = 0;
      end
      queue_fill = 0; queue_read = 0;
      pending_irq = 0; sticky_shift = 0; in_version_reply = 0;
      output_enable_flag = 0; key_busy = 0;
      match_pos = 0; reply_pos = 0;
      btn_valid = 0; btn_down = 0; btn_id = 0;
      key_valid = 0; key_ctl = 0; key_sh = 0; key_ch = 0;
      error_count = 0;
   endfunction

   function void set_both(int col, logic [7:0] m);
      pressed_map[col] |= m;
      latched_map[col] |= m;
   endfunction

   function void clear_both(int col, logic [7:0] m);
      pressed_map[col] &= ~m;
      latched_map[col] &= ~m;
   endfunction

   // apply a posted button to the matrix
   function void apply_button();
      logic [7:0] code, m;
      int col;
      btn_valid = 0;
      if (btn_id inside {6'd27, 6'd28, 6'd29}) begin
         col = (btn_id == 27) ? 11 : (btn_id == 28) ? 6 : 3;
         m = (btn_id == 27) ? 8'h80 : (btn_id == 28) ? 8'h10 : 8'h02;
         if (btn_down) begin
            if ((pressed_map[col] & m) == 0) set_both(col, m);
            else clear_both(col, m);
         end
         return;
      end
      if (btn_id == 30 || btn_id == 31) begin
         if (btn_down) begin
            m = (btn_id == 30) ? 8'h01 : 8'h40;
            if ((pressed_map[9] & m) == 0) begin
               set_both(9, m);
               sticky_shift = 1;
            end else begin
               clear_both(9, m);
               sticky_shift = 0;
            end
         end
         return;
      end
      if (btn_id == 32) begin
         if (btn_down) begin
            clear_both(11, 8'h80);
            clear_both(6, 8'h10);
            clear_both(9, 8'h41);
            clear_both(3, 8'h02);
         end
         return;
      end
      code = skc_pkg::button_code(btn_id);
      if (code[7] == 0) begin
         m = 8'h01 << code[6:4];
         if (btn_down) set_both(code[3:0], m);
         else clear_both(code[3:0], m);
      end
      if (code == 8'h12 || code == 8'h70) begin
         if (btn_down) set_both(6, 8'h10);
         else clear_both(6, 8'h10);
      end
   endfunction

   function void apply_key();
      logic [7:0] code, m;
      int col;
      code = key_ch[7] ? 8'h00 : skc_pkg::CHAR_TABLE[key_ch[6:0]];
      col = code[3:0];
      m = 8'h01 << code[6:4];
      if ((pressed_map[col] & m) != 0) return;
      key_valid = 0;
      pressed_map[col] |= m;
      latched_map[col] &= ~m;
      if (!sticky_shift) begin
         if (key_sh) pressed_map[9] |= 8'h01;
         else pressed_map[9] &= 8'hfe;
         latched_map[9] &= 8'hfe;
      end
      key_busy = 1;
   endfunction

   function logic [7:0] match_version(logic [7:0] cmd);
      logic [7:0] r;
      r = 0;
      if (in_version_reply) begin
         r = skc_pkg::VER_TEXT[reply_pos[1:0]];
         reply_pos = reply_pos + 1;
         if (reply_pos >= 4) begin
            match_pos = 0;
            reply_pos = 0;
            in_version_reply = 0;
         end
      end else if (skc_pkg::CMD_TEXT[match_pos[2:0]] == cmd) begin
         match_pos = match_pos + 1;
         if (match_pos >= 8) begin
            in_version_reply = 1;
            reply_pos = 0;
         end
      end else begin
         match_pos = 0;
      end
      return r;
   endfunction

   function void scan_matrix();
      bit blocked;
      logic [7:0] m;
      blocked = key_busy;
      key_busy = 0;
      if (btn_valid) apply_button();
      if (key_valid && !key_ctl && !blocked) apply_key();
      queue_fill = 0;
      for (int c = 0; c < 16; c++)
         for (int b = 0; b < 8; b++) begin
            m = 8'h01 << b;
            if ((pressed_map[c] & m) != 0) begin
               scan_queue[queue_fill[6:0]] = {b[3:0], c[3:0]};
               queue_fill = queue_fill + 1;
               if ((latched_map[c] & m) == 0) pressed_map[c] &= ~m;
            end
         end
   endfunction

   // note an accepted request and queue its expected answer
   function void note_request(logic [2:0] kind, logic [15:0] word, logic [5:0] bid,
                              bit bdown, logic [7:0] ch, bit sh, bit ctl);
      answer_type a;
      a = '0;
      case (kind)
         skc_pkg::REQ_EXCHANGE: begin
            if (output_enable_flag) begin
               queue_fill = 0; queue_read = 0;
               output_enable_flag = 0;
               a.read_data = skc_pkg::OE_REPLY;
            end else if (word != 0 || in_version_reply) begin
               a.read_data = match_version(word[7:0]);
               queue_fill = 0; queue_read = 0;
            end else if (queue_fill != 0) begin
               a.read_data = scan_queue[queue_read[6:0]];
               queue_read = queue_read + 1;
               if (queue_read == queue_fill) begin
                  queue_fill = 0; queue_read = 0;
               end
            end else begin
               scan_matrix();
               queue_read = 0;
               a.read_data = queue_fill ? (queue_fill | skc_pkg::COUNT_FLAG) : 8'h00;
               pending_irq = 0;
            end
         end
         skc_pkg::REQ_OUT_EN: output_enable_flag = 1;
         skc_pkg::REQ_BUTTON: begin
            btn_valid = 1; btn_id = bid; btn_down = bdown;
         end
         skc_pkg::REQ_KEY: begin
            key_valid = 1; key_ch = ch; key_sh = sh; key_ctl = ctl;
         end
         skc_pkg::REQ_IRQ_POLL: begin
            if (!pending_irq) pending_irq = btn_valid || (key_valid && !key_ctl);
            a.irq_request = pending_irq;
         end
         default: ;
      endcase
      pending_answers.push_back(a);
   endfunction

   task report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task check_answer(logic [7:0] data, logic irq);
      answer_type a;
      if (pending_answers.size() == 0) begin
         report_mismatch("unexpected answer", data, 0);
         return;
      end
      a = pending_answers.pop_front();
      if (data !== a.read_data) report_mismatch("read_data", data, a.read_data);
      if (irq !== a.irq_request) report_mismatch("irq_request", irq, a.irq_request);
   endtask
endclass

module tb_top;
   localparam int STALL_LIMIT = 2000;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [2:0]  req_type = 0;
   logic [15:0] req_spi_word = 0;
   logic [5:0]  req_button_id = 0;
   logic        req_button_down = 0;
   logic [7:0]  req_key_char = 0;
   logic        req_key_shift = 0;
   logic        req_key_control = 0;
   logic        rsp_valid;
   logic [7:0]  rsp_read_data;
   logic        rsp_irq_request;

   keyboard_scoreboard board = new();
   int idle_cycles = 0;
   int sent_count = 0;
   bit quiet_stretch = 0;

   spi_keyboard_controller_core u_dut (
      .clock, .reset, .start, .busy,
      .req_type, .req_spi_word, .req_button_id, .req_button_down,
      .req_key_char, .req_key_shift, .req_key_control,
      .rsp_valid, .rsp_read_data, .rsp_irq_request
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // check answers; watch for a stalled block
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_answer(rsp_read_data, rsp_irq_request);
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // present one transaction and hold it until accepted; start stays high afterwards
   task automatic send_request(logic [2:0] kind, logic [15:0] word, logic [5:0] bid,
                               bit bdown, logic [7:0] ch, bit sh, bit ctl);
      if (!quiet_stretch)
         while ($urandom_range(0, 99) < 11) begin
            start <= 0;
            @(posedge clock);
         end
      start <= 1;
      req_type <= kind;
      req_spi_word <= word;
      req_button_id <= bid;
      req_button_down <= bdown;
      req_key_char <= ch;
      req_key_shift <= sh;
      req_key_control <= ctl;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(kind, word, bid, bdown, ch, sh, ctl);
      sent_count++;
   endtask

   task automatic exchange_word(logic [15:0] word);
      send_request(skc_pkg::REQ_EXCHANGE, word, 6'($urandom), 1'($urandom), 8'($urandom),
                   1'($urandom), 1'($urandom));
   endtask

   task automatic post_button(logic [5:0] bid, bit bdown);
      send_request(skc_pkg::REQ_BUTTON, 16'($urandom), bid, bdown, 8'($urandom),
                   1'($urandom), 1'($urandom));
   endtask

   task automatic post_key(logic [7:0] ch, bit sh, bit ctl);
      send_request(skc_pkg::REQ_KEY, 16'($urandom), 6'($urandom), 1'($urandom), ch, sh, ctl);
   endtask

   task automatic simple_request(logic [2:0] kind);
      send_request(kind, 16'($urandom), 6'($urandom), 1'($urandom), 8'($urandom),
                   1'($urandom), 1'($urandom));
   endtask

   // scan, then read the whole queue out
   task automatic drain_queue();
      int n;
      exchange_word(16'h0000);
      n = board.queue_fill;
      for (int i = 0; i < n; i++) exchange_word(16'h0000);
   endtask

   task automatic send_version_command(bit corrupt);
      logic [7:0] cmd [8];
      cmd = skc_pkg::CMD_TEXT;
      if (corrupt) cmd[$urandom_range(0, 7)] = 8'($urandom);
      for (int i = 0; i < 8; i++) exchange_word({8'($urandom_range(0, 255)), cmd[i]});
      for (int i = 0; i < 4; i++) exchange_word(16'($urandom));
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         post_button($urandom_range(0, 99) < 85 ? 6'($urandom_range(0, 32)) : 6'($urandom),
                     1'($urandom));
         simple_request(skc_pkg::REQ_IRQ_POLL);
         drain_queue();
      end else if (pick < 55) begin
         post_key(8'($urandom), 1'($urandom), $urandom_range(0, 99) < 15);
         simple_request(skc_pkg::REQ_IRQ_POLL);
         drain_queue();
         drain_queue();
      end else if (pick < 63) send_version_command($urandom_range(0, 3) == 0);
      else if (pick < 70) begin
         simple_request(skc_pkg::REQ_OUT_EN);
         exchange_word(16'($urandom));
      end else if (pick < 80) exchange_word($urandom_range(0, 1) ? 16'h0000 : 16'($urandom));
      else if (pick < 95) simple_request(3'($urandom_range(0, 4)));
      else simple_request(3'($urandom_range(5, 7)));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every request type, special cases
      exchange_word(16'h0000);
      simple_request(skc_pkg::REQ_IRQ_POLL);
      post_button(6'd0, 1);
      drain_queue();
      post_button(6'd63, 1);
      drain_queue();
      post_button(6'd30, 1);
      post_key(8'h41, 1, 0);
      drain_queue();
      drain_queue();
      post_button(6'd32, 1);
      post_key(8'hff, 0, 0);
      drain_queue();
      post_key(8'h7f, 1, 1);
      simple_request(skc_pkg::REQ_IRQ_POLL);
      exchange_word(16'hff00);
      send_version_command(0);
      simple_request(skc_pkg::REQ_OUT_EN);
      exchange_word(16'hffff);
      simple_request(3'd7);

      // pause until every answer is in
      start <= 0;
      while (board.pending_answers.size() != 0) @(posedge clock);

      while (sent_count < 1300) begin
         quiet_stretch = (sent_count >= 400 && sent_count < 600);
         random_item();
      end

      start <= 0;
      while (board.pending_answers.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.error_count == 0 && board.pending_answers.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire
